>>> src/ppdq_pkg.sv
package ppdq_pkg;

  // Field widths fixed by the interface
  localparam int unsigned HandleW  = 16;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  // Register map
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PACKET_DELAY = 1'b0,
    CFG_BYPASS       = 1'b1
  } cfg_idx_t;

  // Input opcodes
  typedef enum logic {
    OP_ARRIVAL = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  // Sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HEAD = 2'b10
  } state_t;

  // Queue control from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic rd_req;
  } fifo_ctl_t;

  // Queue status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
    logic last;   // exactly one entry held
  } fifo_sts_t;

endpackage

>>> src/packet_pacing_delay_queue.sv
// Packet pacing delay queue: spaces packets out to a programmed rate.
//
// Input channel (in_valid / in_stall): one beat is either a packet arrival
// (opcode arrival, with a handle) or a one-millisecond tick. Every input
// beat yields exactly one output beat on out_valid / out_stall.
// An arrival is stamped with a release time max(next slot, now) and queued;
// the next slot then moves on by packet_delay_ms. In bypass mode or with
// the queue full the packet goes straight out. A tick advances the clock
// and, with bypass off, releases the queue head once now > its release time.
//
// An arrival, or a tick that finds the queue empty or bypass set, has its
// result registered at the accepting edge. A tick with packets held goes
// through ST_HEAD: the head entry comes out of the queue memory in the
// cycle after the read is issued, and the result is registered from it.
// The output beat sits in a register; the block takes a new input beat
// while that register is being drained in the same cycle. If the receiver
// stalls, the result holds and in_stall rises until it is taken.
// Reset (rst_n low, synchronous) empties the queue, zeroes both clocks and
// loads delay 10 ms, bypass off. Queue memory is not cleared.
module packet_pacing_delay_queue #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned HANDLE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [ppdq_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ppdq_pkg::CfgDataW-1:0]   cfg_data,
  // input beats
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [ppdq_pkg::HandleW-1:0]    in_packet_handle,
  // output beats
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_packet_valid,
  output logic [ppdq_pkg::HandleW-1:0]    out_leaving_handle,
  output logic                            out_was_delayed,
  output logic                            out_still_holding
);
  import ppdq_pkg::*;

  // Stored handle keeps only the bits that survive both masks
  localparam int unsigned StoreHW = (HANDLE_BITS < HandleW) ? HANDLE_BITS : HandleW;
  localparam int unsigned EntryW  = StoreHW + TimeW;

  // Config registers
  logic [DelayW-1:0] delay_r, delay_nxt;
  logic              bypass_r, bypass_nxt;

  // Timekeeping
  logic [TimeW-1:0]  now_r, now_nxt;
  logic [TimeW-1:0]  next_slot_r, next_slot_nxt;
  logic [TimeW-1:0]  release_time;

  state_t            state_r, state_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_pkt_r, out_pkt_nxt;
  logic [HandleW-1:0] out_handle_r, out_handle_nxt;
  logic              out_delayed_r, out_delayed_nxt;
  logic              out_holding_r, out_holding_nxt;

  // Queue
  fifo_ctl_t         fctl;
  fifo_sts_t         fsts;
  logic [EntryW-1:0] wr_entry;
  logic [EntryW-1:0] head_entry;
  logic [StoreHW-1:0] head_handle;
  logic [TimeW-1:0]  head_release;

  logic              in_acc;
  logic              out_free;

  ppdq_fifo #(
    .DEPTH (BUFFER_DEPTH),
    .DW    (EntryW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fctl),
    .wr_data (wr_entry),
    .rd_data (head_entry),
    .sts     (fsts)
  );

  assign head_handle  = head_entry[EntryW-1:TimeW];
  assign head_release = head_entry[TimeW-1:0];

  // Output register empty or emptying this cycle
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign release_time = (next_slot_r > now_r) ? next_slot_r : now_r;
  assign wr_entry     = {in_packet_handle[StoreHW-1:0], release_time};

  // Config decode
  always_comb begin
    delay_nxt  = delay_r;
    bypass_nxt = bypass_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PACKET_DELAY: delay_nxt  = cfg_data;
        CFG_BYPASS:       bypass_nxt = cfg_data[0];
        default:          ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    now_nxt         = now_r;
    next_slot_nxt   = next_slot_r;
    fctl            = '0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_pkt_nxt     = out_pkt_r;
    out_handle_nxt  = out_handle_r;
    out_delayed_nxt = out_delayed_r;
    out_holding_nxt = out_holding_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_t'(in_opcode) == OP_ARRIVAL) begin
            out_valid_nxt   = 1'b1;
            out_delayed_nxt = 1'b0;
            if (bypass_r || fsts.full) begin
              // straight through, slot untouched
              out_pkt_nxt     = 1'b1;
              out_handle_nxt  = HandleW'(in_packet_handle[StoreHW-1:0]);
              out_holding_nxt = !fsts.empty;
            end else begin
              fctl.push       = 1'b1;
              next_slot_nxt   = release_time + TimeW'(delay_r);
              out_pkt_nxt     = 1'b0;
              out_handle_nxt  = '0;
              out_holding_nxt = 1'b1;
            end
          end else begin
            now_nxt = now_r + 1'b1;
            if (bypass_r || fsts.empty) begin
              out_valid_nxt   = 1'b1;
              out_pkt_nxt     = 1'b0;
              out_handle_nxt  = '0;
              out_delayed_nxt = 1'b0;
              out_holding_nxt = !fsts.empty;
            end else begin
              // fetch head, decide next cycle
              fctl.rd_req = 1'b1;
              state_nxt   = ST_HEAD;
            end
          end
        end
      end
      ST_HEAD: begin
        // now_r already holds the advanced time
        out_valid_nxt = 1'b1;
        if (now_r > head_release) begin
          fctl.pop        = 1'b1;
          out_pkt_nxt     = 1'b1;
          out_handle_nxt  = HandleW'(head_handle);
          out_delayed_nxt = 1'b1;
          out_holding_nxt = !fsts.last;
        end else begin
          out_pkt_nxt     = 1'b0;
          out_handle_nxt  = '0;
          out_delayed_nxt = 1'b0;
          out_holding_nxt = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r     <= DelayW'(10);
      bypass_r    <= 1'b0;
      now_r       <= '0;
      next_slot_r <= '0;
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      delay_r     <= delay_nxt;
      bypass_r    <= bypass_nxt;
      now_r       <= now_nxt;
      next_slot_r <= next_slot_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pkt_r     <= out_pkt_nxt;
    out_handle_r  <= out_handle_nxt;
    out_delayed_r <= out_delayed_nxt;
    out_holding_r <= out_holding_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_packet_valid   = out_pkt_r;
  assign out_leaving_handle = out_handle_r;
  assign out_was_delayed    = out_delayed_r;
  assign out_still_holding  = out_holding_r;

`ifndef SYNTHESIS
  // head lookup never lingers
  a_head_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HEAD |=> state_r == ST_IDLE)
    else $error("head lookup lasted more than one cycle");

  // head result lands in an empty output register
  a_head_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HEAD |-> !out_valid_r)
    else $error("head result would overwrite pending output");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fctl.pop |-> !fsts.empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    fctl.push |-> !fsts.full)
    else $error("push into full queue");
`endif

endmodule

>>> src/ppdq_fifo.sv
module ppdq_fifo #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DW    = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppdq_pkg::fifo_ctl_t  ctl,
  input  logic [DW-1:0]        wr_data,
  output logic [DW-1:0]        rd_data,
  output ppdq_pkg::fifo_sts_t  sts
);
  import ppdq_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]   rd_data_r;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = ctl.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = ctl.pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (ctl.push && !ctl.pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Single write port, single registered read port
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (ctl.rd_req) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  assign rd_data   = rd_data_r;
  assign sts.empty = (cnt_r == '0);
  assign sts.full  = (cnt_r == CntW'(DEPTH));
  assign sts.last  = (cnt_r == CntW'(1));

endmodule
